// File: rtl/bcomp_pkg.sv
// ---------------------------------------------------------------------------
// bcomp_pkg
// Shared constants and types of the barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bcomp_pkg;

    localparam int unsigned QUO_W      = 64;
    localparam int unsigned DVS_W      = 31;
    localparam int unsigned DIV_BITS   = 2;
    localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS;

    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic [31:0]        TEMP_ROUND  = 32'd128;
    localparam logic [63:0]        DIV_BIAS    = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        CFG_TEMP  = 2'd0,
        CFG_PLOW  = 2'd1,
        CFG_PMID  = 2'd2,
        CFG_PHIGH = 2'd3
    } t_cfg_idx;

    // sideband carried alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        zero;
        logic        qneg;
    } t_div_side;

endpackage

// File: rtl/bcomp_div.sv
// ---------------------------------------------------------------------------
// bcomp_div
// Pipelined unsigned restoring divider, 64-bit dividend by 31-bit divisor,
// DIV_BITS quotient bits per stage.
// ---------------------------------------------------------------------------
module bcomp_div
    import bcomp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [QUO_W-1:0]   i_dividend,
    input  logic [DVS_W-1:0]   i_divisor,
    input  t_div_side          i_side,
    output logic               o_valid,
    output logic [QUO_W-1:0]   o_quotient,
    output t_div_side          o_side
);

    logic             r_vld  [DIV_STAGES];
    logic [QUO_W-1:0] r_q    [DIV_STAGES];
    logic [DVS_W-1:0] r_rem  [DIV_STAGES];
    logic [DVS_W-1:0] r_dvs  [DIV_STAGES];
    t_div_side        r_side [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic             s_vld;
        logic [QUO_W-1:0] s_q;
        logic [DVS_W-1:0] s_rem;
        logic [DVS_W-1:0] s_dvs;
        t_div_side        s_side;
        logic [QUO_W-1:0] n_q;
        logic [DVS_W-1:0] n_rem;
        logic [DVS_W:0]   trial;
        logic             qbit;

        if (g == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_q    = i_dividend;
            assign s_rem  = '0;
            assign s_dvs  = i_divisor;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[g-1];
            assign s_q    = r_q[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_dvs  = r_dvs[g-1];
            assign s_side = r_side[g-1];
        end

        // dividend bits leave at the top of s_q, quotient bits enter at the bottom
        always_comb begin
            n_q   = s_q;
            n_rem = s_rem;
            trial = '0;
            qbit  = 1'b0;
            for (int k = 0; k < DIV_BITS; k++) begin
                trial = {n_rem, n_q[QUO_W-1]};
                if (trial >= {1'b0, s_dvs}) begin
                    trial = trial - {1'b0, s_dvs};
                    qbit  = 1'b1;
                end else begin
                    qbit  = 1'b0;
                end
                n_rem = trial[DVS_W-1:0];
                n_q   = {n_q[QUO_W-2:0], qbit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]    <= n_q;
                r_rem[g]  <= n_rem;
                r_dvs[g]  <= s_dvs;
                r_side[g] <= s_side;
            end
        end
    end

    assign o_valid    = r_vld[DIV_STAGES-1];
    assign o_quotient = r_q[DIV_STAGES-1];
    assign o_side     = r_side[DIV_STAGES-1];

endmodule

// File: rtl/barometric_compensation.sv
// ---------------------------------------------------------------------------
// barometric_compensation
// Integer temperature and pressure compensation of a digital barometer,
// fully pipelined.
// ---------------------------------------------------------------------------
//  channel   ports                               dir   item
//  in        i_in_valid / o_in_ready             in    raw temperature, pressure
//  out       o_out_valid / i_out_ready           out   temperature, pressure, flag
//  cfg       i_cfg_valid / o_cfg_ready           in    register index, data
//
//  One item per cycle while the skid register is empty; 9 stages before the divider,
//  32 divider stages (2 quotient bits each), 5 stages after it.
//  A skid register on the output lets the pipeline take one more step when
//  the output stalls; the pipeline then holds until the skid drains.
//  Synchronous active-low reset clears valid bits and calibration registers.
// ---------------------------------------------------------------------------
module barometric_compensation
    import bcomp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_divisor_zero,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    // calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pl;
    logic [63:0] r_cal_pm;
    logic [15:0] r_cal_ph;

    logic [15:0]        ct1, cp1;
    logic signed [15:0] ct2, ct3, cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9;

    assign ct1 = r_cal_t[15:0];
    assign ct2 = $signed(r_cal_t[31:16]);
    assign ct3 = $signed(r_cal_t[47:32]);
    assign cp1 = r_cal_pl[15:0];
    assign cp2 = $signed(r_cal_pl[31:16]);
    assign cp3 = $signed(r_cal_pl[47:32]);
    assign cp4 = $signed(r_cal_pl[63:48]);
    assign cp5 = $signed(r_cal_pm[15:0]);
    assign cp6 = $signed(r_cal_pm[31:16]);
    assign cp7 = $signed(r_cal_pm[47:32]);
    assign cp8 = $signed(r_cal_pm[63:48]);
    assign cp9 = $signed(r_cal_ph);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pl <= '0;
            r_cal_pm <= '0;
            r_cal_ph <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP:  r_cal_t  <= i_cfg_data[47:0];
                CFG_PLOW:  r_cal_pl <= i_cfg_data;
                CFG_PMID:  r_cal_pm <= i_cfg_data;
                CFG_PHIGH: r_cal_ph <= i_cfg_data[15:0];
                default:   r_cal_ph <= r_cal_ph;
            endcase
        end
    end

    // pipeline control
    logic       en;
    logic       r_skid_valid;
    logic [9:1] r_vpre;
    logic [5:1] r_vpost;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // stage 1: temperature differences and first products
    logic signed [17:0] c1_a;
    logic signed [16:0] c1_d;
    logic signed [33:0] c1_at2;
    logic signed [33:0] c1_dd;
    logic [31:0]        r1_at2, r1_dd;
    logic [20:0]        r1_pp;

    assign c1_a   = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, ct1, 1'b0});
    assign c1_d   = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, ct1});
    assign c1_at2 = c1_a * ct2;
    assign c1_dd  = c1_d * c1_d;

    // stage 2
    logic signed [35:0] c2_x;
    logic [31:0]        r2_x;
    logic [20:0]        r2_v1;
    logic [20:0]        r2_pp;

    assign c2_x = $signed(r1_dd[31:12]) * ct3;

    // stage 3: fine temperature
    logic [31:0]        c3_fine;
    logic signed [32:0] c3_pv1;
    logic [31:0]        r3_fine;
    logic signed [32:0] r3_pv1;
    logic [20:0]        r3_pp;

    assign c3_fine = 32'($signed(r2_v1)) + 32'($signed(r2_x[31:14]));
    assign c3_pv1  = $signed({c3_fine[31], c3_fine}) - FINE_OFFSET;

    // stage 4: temperature result, first pressure products
    logic [31:0]        c4_t5;
    logic signed [65:0] c4_sq;
    logic signed [48:0] c4_m5, c4_m2;
    logic signed [63:0] r4_sq;
    logic [48:0]        r4_m5, r4_m2;
    logic [31:0]        r4_temp;
    logic [20:0]        r4_pp;

    assign c4_t5 = r3_fine + {r3_fine[29:0], 2'b00} + TEMP_ROUND;
    assign c4_sq = r3_pv1 * r3_pv1;
    assign c4_m5 = r3_pv1 * cp5;
    assign c4_m2 = r3_pv1 * cp2;

    // stage 5
    logic signed [79:0] c5_a6, c5_a3;
    logic [63:0]        r5_a6, r5_a3;
    logic [48:0]        r5_m5, r5_m2;
    logic [31:0]        r5_temp;
    logic [20:0]        r5_pp;

    assign c5_a6 = r4_sq * cp6;
    assign c5_a3 = r4_sq * cp3;

    // stage 6: sums for numerator and divisor
    logic [63:0]        c6_v2, c6_base;
    logic [63:0]        r6_v2;
    logic signed [63:0] r6_base;
    logic [31:0]        r6_temp;
    logic [20:0]        r6_pp;

    assign c6_v2   = r5_a6 + {r5_m5[46:0], 17'b0} + {{13{cp4[15]}}, cp4, 35'b0};
    assign c6_base = {{8{r5_a3[63]}}, r5_a3[63:8]} + {{3{r5_m2[48]}}, r5_m2, 12'b0}
                     + DIV_BIAS;

    // stage 7
    logic signed [80:0] c7_w;
    logic [63:0]        c7_numa;
    logic [63:0]        r7_w, r7_numa;
    logic [31:0]        r7_temp;

    assign c7_w    = r6_base * $signed({1'b0, cp1});
    assign c7_numa = {12'b0, r6_pp, 31'b0} - r6_v2;

    // stage 8: divisor and scaled numerator
    logic [63:0]      c8_num;
    logic [63:0]      r8_num;
    logic [DVS_W-1:0] r8_dvs;
    logic             r8_zero;
    logic [31:0]      r8_temp;

    assign c8_num = r7_numa * 64'(PRESS_SCALE);

    // stage 9: magnitudes for the divider
    logic [QUO_W-1:0] r9_ma;
    logic [DVS_W-1:0] r9_mb;
    t_div_side        r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre <= '0;
        end else if (en) begin
            r_vpre <= {r_vpre[8:1], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_at2  <= c1_at2[31:0];
            r1_dd   <= c1_dd[31:0];
            r1_pp   <= PRESS_FULL - {1'b0, i_raw_pressure};

            r2_x    <= c2_x[31:0];
            r2_v1   <= r1_at2[31:11];
            r2_pp   <= r1_pp;

            r3_fine <= c3_fine;
            r3_pv1  <= c3_pv1;
            r3_pp   <= r2_pp;

            r4_sq   <= c4_sq[63:0];
            r4_m5   <= c4_m5;
            r4_m2   <= c4_m2;
            r4_temp <= 32'($signed(c4_t5) >>> 8);
            r4_pp   <= r3_pp;

            r5_a6   <= c5_a6[63:0];
            r5_a3   <= c5_a3[63:0];
            r5_m5   <= r4_m5;
            r5_m2   <= r4_m2;
            r5_temp <= r4_temp;
            r5_pp   <= r4_pp;

            r6_v2   <= c6_v2;
            r6_base <= c6_base;
            r6_temp <= r5_temp;
            r6_pp   <= r5_pp;

            r7_w    <= c7_w[63:0];
            r7_numa <= c7_numa;
            r7_temp <= r6_temp;

            r8_num  <= c8_num;
            r8_dvs  <= r7_w[63:33];
            r8_zero <= (r7_w[63:33] == '0);
            r8_temp <= r7_temp;

            r9_ma        <= r8_num[63] ? (64'd0 - r8_num) : r8_num;
            r9_mb        <= r8_dvs[DVS_W-1] ? (31'd0 - r8_dvs) : r8_dvs;
            r9_side.temp <= r8_temp;
            r9_side.zero <= r8_zero;
            r9_side.qneg <= r8_num[63] ^ r8_dvs[DVS_W-1];
        end
    end

    // divider
    logic             div_valid;
    logic [QUO_W-1:0] div_quo;
    t_div_side        div_side;

    bcomp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_vpre[9]),
        .i_dividend (r9_ma),
        .i_divisor  (r9_mb),
        .i_side     (r9_side),
        .o_valid    (div_valid),
        .o_quotient (div_quo),
        .o_side     (div_side)
    );

    // post stage 1: signed quotient
    logic [63:0] rp1_q;
    t_div_side   rp1_side;

    // post stage 2: square of q/2^13 (low 64 bits) and p8 product
    logic [63:0]        c2p_ll;
    logic signed [51:0] c2p_hl;
    logic signed [79:0] c2p_m8;
    logic [63:0]        rp2_ll, rp2_m8, rp2_q;
    logic [30:0]        rp2_hl;
    t_div_side          rp2_side;

    assign c2p_ll = rp1_q[44:13] * rp1_q[44:13];
    assign c2p_hl = $signed(rp1_q[63:45]) * $signed({1'b0, rp1_q[44:13]});
    assign c2p_m8 = $signed(rp1_q) * cp8;

    // post stage 3
    logic [63:0] rp3_aa, rp3_m8, rp3_q;
    t_div_side   rp3_side;

    // post stage 4
    logic signed [79:0] c4p_m9;
    logic [63:0]        rp4_m9, rp4_m8, rp4_q;
    t_div_side          rp4_side;

    assign c4p_m9 = $signed(rp3_aa) * cp9;

    // post stage 5: final sum
    logic [63:0] c5p_sum;
    logic [31:0] c5p_res;
    logic [31:0] rp5_temp, rp5_press;
    logic        rp5_zero;

    assign c5p_sum = rp4_q + {{25{rp4_m9[63]}}, rp4_m9[63:25]}
                     + {{19{rp4_m8[63]}}, rp4_m8[63:19]};
    assign c5p_res = c5p_sum[39:8] + {{12{cp7[15]}}, cp7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpost <= '0;
        end else if (en) begin
            r_vpost <= {r_vpost[4:1], div_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp1_q     <= div_side.qneg ? (64'd0 - div_quo) : div_quo;
            rp1_side  <= div_side;

            rp2_ll    <= c2p_ll;
            rp2_hl    <= c2p_hl[30:0];
            rp2_m8    <= c2p_m8[63:0];
            rp2_q     <= rp1_q;
            rp2_side  <= rp1_side;

            rp3_aa    <= rp2_ll + {rp2_hl, 33'b0};
            rp3_m8    <= rp2_m8;
            rp3_q     <= rp2_q;
            rp3_side  <= rp2_side;

            rp4_m9    <= c4p_m9[63:0];
            rp4_m8    <= rp3_m8;
            rp4_q     <= rp3_q;
            rp4_side  <= rp3_side;

            rp5_temp  <= rp4_side.temp;
            rp5_zero  <= rp4_side.zero;
            rp5_press <= rp4_side.zero ? 32'd0 : c5p_res;
        end
    end

    // output skid
    logic [31:0] r_sk_temp, r_sk_press;
    logic        r_sk_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_vpost[5] && !i_out_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && r_vpost[5] && !i_out_ready) begin
            r_sk_temp  <= rp5_temp;
            r_sk_press <= rp5_press;
            r_sk_zero  <= rp5_zero;
        end
    end

    assign o_out_valid         = r_skid_valid || r_vpost[5];
    assign o_temperature_centi = r_skid_valid ? $signed(r_sk_temp) : $signed(rp5_temp);
    assign o_pressure_q24_8    = r_skid_valid ? r_sk_press : rp5_press;
    assign o_divisor_zero      = r_skid_valid ? r_sk_zero : rp5_zero;

    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divisor_zero |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure not forced to zero on zero divisor");

    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_vpost[5] && !i_out_ready))
        else $error("skid loaded without a stalled result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_ready |=> r_skid_valid && $stable(r_sk_press))
        else $error("stalled skid item lost or changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for barometric_compensation: drives raw conversion
// pairs under random idling and backpressure, predicts each compensated
// item and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench
    import bcomp_pkg::*;
();

    typedef struct packed {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic               zero;
    } t_reading;

    localparam int unsigned PIPE_DRAIN = 60;    // pipeline latency plus margin
    localparam int unsigned STALL_MAX  = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [19:0]        i_raw_temperature;
    logic [19:0]        i_raw_pressure;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_temperature_centi;
    logic [31:0]        o_pressure_q24_8;
    logic               o_divisor_zero;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;

    // calibration as the block should hold it
    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_pmid;
    logic [15:0] cal_phigh;

    t_reading readings_q[$];
    int       errors;
    bit       send_busy;     // sender draws gaps only when set
    bit       recv_busy;     // receiver draws stalls only when set
    bit       hold_tog;
    bit       hold_seen;
    int       hold_left;
    int       rdy_wait;
    int       quiet_cycles;

    barometric_compensation u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_pressure      (i_raw_pressure),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_divisor_zero      (o_divisor_zero),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // starts low so the first rising edge comes after the reset is driven
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_reading compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
        int       ti;
        int       t1;
        int       t2;
        int       t3;
        int       a;
        int       d;
        int       tv1;
        int       tv2;
        int       fine;
        longint   p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint   v1;
        longint   v2;
        longint   num;
        longint   p;
        longint   q;
        t_reading r;
        ti   = int'(adc_t);
        t1   = int'(cal_temp[15:0]);
        t2   = int'($signed(cal_temp[31:16]));
        t3   = int'($signed(cal_temp[47:32]));
        a    = (ti >> 3) - (t1 << 1);
        tv1  = (a * t2) >>> 11;
        d    = (ti >> 4) - t1;
        tv2  = (((d * d) >>> 12) * t3) >>> 14;
        fine = tv1 + tv2;
        r.temp = (fine * 5 + 128) >>> 8;

        p1 = longint'(cal_plow[15:0]);
        p2 = longint'($signed(cal_plow[31:16]));
        p3 = longint'($signed(cal_plow[47:32]));
        p4 = longint'($signed(cal_plow[63:48]));
        p5 = longint'($signed(cal_pmid[15:0]));
        p6 = longint'($signed(cal_pmid[31:16]));
        p7 = longint'($signed(cal_pmid[47:32]));
        p8 = longint'($signed(cal_pmid[63:48]));
        p9 = longint'($signed(cal_phigh));

        v1 = longint'(fine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
            r.press = '0;
            r.zero  = 1'b1;
        end else begin
            p   = 64'sd1048576 - longint'(adc_p);
            num = ((p <<< 31) - v2) * 64'sd3125;
            // most negative over minus one wraps to itself
            if (v1 == -64'sd1) p = -num;
            else p = num / v1;
            q  = p >>> 13;
            v1 = (p9 * q * q) >>> 25;
            v2 = (p8 * p) >>> 19;
            p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
            r.zero  = 1'b0;
        end
        return r;
    endfunction

    // receiver: per-item stall draw, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rdy_wait    <= 0;
            hold_left   <= 0;
            hold_seen   <= hold_tog;
        end else if (hold_tog != hold_seen) begin
            hold_seen   <= hold_tog;
            hold_left   <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!i_out_ready) begin
            if (rdy_wait == 0) i_out_ready <= 1'b1;
            else rdy_wait <= rdy_wait - 1;
        end else if (o_out_valid && recv_busy && $urandom_range(0, 2) != 0) begin
            i_out_ready <= 1'b0;
            rdy_wait    <= $urandom_range(0, 13);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (readings_q.size() == 0) begin
                $display("%0t: unexpected item temp=%0d press=%h zero=%b", $time,
                         o_temperature_centi, o_pressure_q24_8, o_divisor_zero);
                errors++;
            end else begin
                exp_r = readings_q.pop_front();
                if (o_temperature_centi !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             exp_r.temp, o_temperature_centi);
                    errors++;
                end
                if (o_pressure_q24_8 !== exp_r.press) begin
                    $display("%0t: pressure expected %h actual %h", $time,
                             exp_r.press, o_pressure_q24_8);
                    errors++;
                end
                if (o_divisor_zero !== exp_r.zero) begin
                    $display("%0t: divisor_zero expected %b actual %b", $time,
                             exp_r.zero, o_divisor_zero);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("barometric_compensation: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p);
        int gap;
        gap = send_busy ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_temperature <= adc_t;
        i_raw_pressure    <= adc_p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        readings_q.push_back(compensate(adc_t, adc_p));
    endtask

    // valid drops at the edge that took the last item
    task automatic drain;
        i_in_valid <= 1'b0;
        while (readings_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cal(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TEMP:  cal_temp  = data[47:0];
            CFG_PLOW:  cal_plow  = data;
            CFG_PMID:  cal_pmid  = data;
            CFG_PHIGH: cal_phigh = data[15:0];
        endcase
    endtask

    task automatic load_cal(input logic [63:0] t, input logic [63:0] lo,
                            input logic [63:0] mid, input logic [63:0] hi);
        drain();
        write_cal(CFG_TEMP, t);
        write_cal(CFG_PLOW, lo);
        write_cal(CFG_PMID, mid);
        write_cal(CFG_PHIGH, hi);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_typical;
        // T1..T3, P1..P9 of a typical part
        load_cal({16'hx, 16'(-1000), 16'd26435, 16'd27504} & 64'h0000_FFFF_FFFF_FFFF,
                 {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
                 {16'(-14600), 16'd15500, 16'(-7), 16'd140},
                 64'd6000);
    endtask

    // zero calibration after reset: divisor is zero
    task automatic test_reset_values;
        send_pair(20'd0, 20'd0);
        send_pair(20'hFFFFF, 20'hFFFFF);
        send_pair(20'h80000, 20'h12345);
    endtask

    task automatic test_directed;
        load_typical();
        send_pair(20'd519888, 20'd415148);
        send_pair(20'd0, 20'd0);
        send_pair(20'hFFFFF, 20'hFFFFF);
        send_pair(20'd0, 20'hFFFFF);
        send_pair(20'hFFFFF, 20'd0);
        send_pair(20'h55555, 20'hAAAAA);
        send_pair(20'hAAAAA, 20'h55555);
        // P1 zero forces the divisor to zero
        load_cal(64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF);
        send_pair(20'd0, 20'd0);
        send_pair(20'hFFFFF, 20'hFFFFF);
        // all ones and signed extremes
        load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(20'd0, 20'd0);
        send_pair(20'hFFFFF, 20'hFFFFF);
        load_cal(64'h0000_8000_7FFF_FFFF, 64'h7FFF_8000_7FFF_FFFF,
                 64'h8000_7FFF_8000_7FFF, 64'h8000);
        send_pair(20'd0, 20'hFFFFF);
        send_pair(20'hFFFFF, 20'd0);
        load_cal(64'h0000_7FFF_8000_0001, 64'h8000_7FFF_8000_0001,
                 64'h7FFF_8000_7FFF_8000, 64'h7FFF);
        send_pair(20'd0, 20'd0);
        send_pair(20'hFFFFF, 20'hFFFFF);
    endtask

    task automatic test_random;
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0) begin
                load_typical();
            end else begin
                load_cal({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            end
            send_busy = (phase != 2);
            recv_busy = (phase != 3);
            for (n = 0; n < 55; n++) begin
                if (phase % 2 == 0 && $urandom_range(0, 3) != 0)
                    send_pair(20'($urandom_range(400000, 600000)),
                              20'($urandom_range(200000, 700000)));
                else
                    send_pair(20'($urandom), 20'($urandom));
            end
        end
        send_busy = 1'b1;
        recv_busy = 1'b1;
    endtask

    // long receiver hold-off while the sender streams
    task automatic test_backpressure;
        int n;
        load_typical();
        send_busy = 1'b0;
        hold_tog  = ~hold_tog;
        for (n = 0; n < 80; n++) send_pair(20'($urandom), 20'($urandom));
        send_busy = 1'b1;
    endtask

    initial begin
        errors            = 0;
        send_busy         = 1'b1;
        recv_busy         = 1'b1;
        hold_tog          = 1'b0;
        quiet_cycles      = 0;
        cal_temp          = '0;
        cal_plow          = '0;
        cal_pmid          = '0;
        cal_phigh         = '0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_TEMP;
        i_cfg_data        = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_random();
        test_backpressure();
        drain();

        if (errors == 0) begin
            $display("barometric_compensation: match");
        end else begin
            $display("barometric_compensation: mismatch");
        end
        $finish;
    end

endmodule
